/* rtl/snc_pkg.sv */
// shared types, constants and helpers of the short name converter
package snc_pkg;

    // payload widths fixed by the port definition
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 4;
    localparam int FLAGS_W = 5;

    // default geometry of the short name
    localparam int NAME_LENGTH_DEF  = 8;
    localparam int TOTAL_LENGTH_DEF = 11;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // characters
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5a;
    localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7a;
    localparam logic [CHAR_W-1:0] CASE_FOLD  = 8'd32;

    // case flags on the output
    localparam logic [FLAGS_W-1:0] FLAG_NAME_LOWER = 5'h08;
    localparam logic [FLAGS_W-1:0] FLAG_EXT_LOWER  = 5'h10;

    // conversion phase
    typedef enum logic [1:0] {
        PH_START,
        PH_NAME,
        PH_EXT
    } phase_t;

    // letters seen in the kept bytes
    typedef struct packed {
        logic ext_up;
        logic ext_lo;
        logic name_up;
        logic name_lo;
    } case_seen_t;

    function automatic logic is_lower(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_LO_A) && (c <= CHAR_LO_Z);
    endfunction

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
    endfunction

    function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
        return is_lower(c) ? (c - CASE_FOLD) : c;
    endfunction

endpackage

/* rtl/short_name_converter.sv */
// top level of the 8.3 short name converter
//
// Input channel (push/full): one file-name byte per request on name_char; a
// zero byte ends the name. Ordinary bytes give no result and are taken one
// per cycle while full is low. Output channel (empty/pop): on each
// terminator the block gives TOTAL_LENGTH results, position 0 up, with the
// converted byte, the case bits and last_of_run on the final byte.
// The first byte of a name reaches the result ports after its terminator is
// taken, through the record queue and then the output register; further
// bytes follow one per cycle while pop is high. The output side sets the
// pace, held by the single byte counter of the back part.
// A two-entry record queue sits between the character front and the byte
// back, so input keeps flowing while a name streams out. A name stays in the
// queue until its last byte is loaded, so full rises while two finished names
// are held, the one streaming out and one behind it: behind a stalled
// receiver, or when names end faster than the back part streams them out.
// Reset clears the name under construction, the queue and the valid flag of the
// output register; empty is high and full low after reset.
module short_name_converter
    import snc_pkg::*;
#(
    parameter int NAME_LENGTH  = NAME_LENGTH_DEF,
    parameter int TOTAL_LENGTH = TOTAL_LENGTH_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [CHAR_W-1:0]  name_char,
    output logic               empty,
    input  logic               pop,
    output logic [POS_W-1:0]   position,
    output logic [CHAR_W-1:0]  short_name_byte,
    output logic [FLAGS_W-1:0] case_bits,
    output logic               last_of_run
);

    localparam int REC_W = TOTAL_LENGTH * CHAR_W + FLAGS_W;

    logic             take;
    logic             rec_push;
    logic [REC_W-1:0] rec_data;
    logic             q_full;
    logic             q_valid;
    logic [REC_W-1:0] q_data;
    logic             head_take;
    logic             out_valid;
    logic             out_pop;

    // request handshakes
    assign take    = push && !q_full;
    assign full    = q_full;
    assign empty   = !out_valid;
    assign out_pop = pop && out_valid;

    snc_front #(
        .NAME_LENGTH  (NAME_LENGTH),
        .TOTAL_LENGTH (TOTAL_LENGTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .name_char (name_char),
        .rec_push  (rec_push),
        .rec_data  (rec_data)
    );

    snc_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (rec_data),
        .rd_en   (head_take),
        .q_full  (q_full),
        .q_valid (q_valid),
        .rd_data (q_data)
    );

    snc_back #(
        .TOTAL_LENGTH (TOTAL_LENGTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_valid),
        .head_data    (q_data),
        .head_take    (head_take),
        .out_pop      (out_pop),
        .out_valid    (out_valid),
        .out_position (position),
        .out_byte     (short_name_byte),
        .out_flags    (case_bits),
        .out_last     (last_of_run)
    );

    // the last byte of a run sits at the final position
    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_of_run) |-> (position == POS_W'(TOTAL_LENGTH - 1)))
        else $error("last_of_run away from the final position");

    // within a run the next byte follows right after a pop
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_of_run) |=>
            (!empty && position == $past(position) + POS_W'(1)))
        else $error("run broken after a pop");

    // no lower-case letter leaves the block
    a_folded: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(short_name_byte >= CHAR_LO_A && short_name_byte <= CHAR_LO_Z))
        else $error("lower-case letter in the short name");

endmodule

/* rtl/snc_front.sv */
// front part: takes name characters, builds the short name, hands off finished names
module snc_front
    import snc_pkg::*;
#(
    parameter int NAME_LENGTH  = NAME_LENGTH_DEF,
    parameter int TOTAL_LENGTH = TOTAL_LENGTH_DEF,
    localparam int REC_W       = TOTAL_LENGTH * CHAR_W + FLAGS_W
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [CHAR_W-1:0] name_char,
    output logic              rec_push,
    output logic [REC_W-1:0]  rec_data
);

    phase_t             phase_reg, phase_next;
    logic [CHAR_W-1:0]  store_reg [TOTAL_LENGTH];
    logic [CHAR_W-1:0]  store_next [TOTAL_LENGTH];
    logic [POS_W-1:0]   write_index_reg, write_index_next;
    logic [1:0]         chars_seen_reg, chars_seen_next;
    logic               all_dots_reg, all_dots_next;
    case_seen_t         case_seen_reg, case_seen_next;

    logic               is_term;
    logic               is_dot;
    logic               in_ext;
    logic               do_put;
    logic               idx_in_store;
    logic               idx_in_name;
    logic               dots_only;
    logic [FLAGS_W-1:0] flags;

    assign is_term      = (name_char == CHAR_NUL);
    assign is_dot       = (name_char == CHAR_DOT);
    assign in_ext       = (phase_reg == PH_EXT);
    assign idx_in_store = ({1'b0, write_index_reg} < (POS_W+1)'(TOTAL_LENGTH));
    assign idx_in_name  = ({1'b0, write_index_reg} < (POS_W+1)'(NAME_LENGTH));

    // a byte goes through folding and case tracking
    always_comb
    begin
        unique case (phase_reg)
            PH_START: do_put = !is_dot;
            PH_NAME:  do_put = !is_dot && idx_in_name;
            PH_EXT:   do_put = idx_in_store;
            default:  do_put = 1'b0;
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            if (is_term)
            begin
                phase_next = PH_START;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START: phase_next = PH_NAME;
                    PH_NAME:  phase_next = is_dot ? PH_EXT : PH_NAME;
                    PH_EXT:   phase_next = PH_EXT;
                    default:  phase_next = PH_START;
                endcase
            end
        end
    end

    // store, index, counters and case tracking
    always_comb
    begin
        store_next       = store_reg;
        write_index_next = write_index_reg;
        chars_seen_next  = chars_seen_reg;
        all_dots_next    = all_dots_reg;
        case_seen_next   = case_seen_reg;
        if (take && is_term)
        begin
            for (int i = 0; i < TOTAL_LENGTH; i++)
            begin
                store_next[i] = CHAR_SPACE;
            end
            write_index_next = '0;
            chars_seen_next  = '0;
            all_dots_next    = 1'b1;
            case_seen_next   = '0;
        end
        else if (take)
        begin
            if (chars_seen_reg != 2'd3)
            begin
                chars_seen_next = chars_seen_reg + 2'd1;
            end
            all_dots_next = all_dots_reg && is_dot;
            if (phase_reg == PH_START && is_dot)
            begin
                store_next[0]    = CHAR_DOT;
                write_index_next = POS_W'(1);
            end
            else if (phase_reg == PH_NAME && is_dot)
            begin
                write_index_next = POS_W'(NAME_LENGTH);
            end
            else if (do_put)
            begin
                if (is_lower(name_char))
                begin
                    if (in_ext) case_seen_next.ext_lo  = 1'b1;
                    else        case_seen_next.name_lo = 1'b1;
                end
                else if (is_upper(name_char))
                begin
                    if (in_ext) case_seen_next.ext_up  = 1'b1;
                    else        case_seen_next.name_up = 1'b1;
                end
                for (int i = 0; i < TOTAL_LENGTH; i++)
                begin
                    if (write_index_reg == POS_W'(i))
                    begin
                        store_next[i] = fold_upper(name_char);
                    end
                end
                write_index_next = write_index_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            write_index_reg <= '0;
            chars_seen_reg  <= '0;
            all_dots_reg    <= 1'b1;
            case_seen_reg   <= '0;
            for (int i = 0; i < TOTAL_LENGTH; i++)
            begin
                store_reg[i] <= CHAR_SPACE;
            end
        end
        else
        begin
            phase_reg       <= phase_next;
            write_index_reg <= write_index_next;
            chars_seen_reg  <= chars_seen_next;
            all_dots_reg    <= all_dots_next;
            case_seen_reg   <= case_seen_next;
            store_reg       <= store_next;
        end
    end

    // finished name record: dot names pass through, flags from case tracking
    assign dots_only = all_dots_reg && (chars_seen_reg == 2'd1 || chars_seen_reg == 2'd2);

    always_comb
    begin
        flags = '0;
        if (!dots_only)
        begin
            if (case_seen_reg.name_lo && !case_seen_reg.name_up) flags = flags | FLAG_NAME_LOWER;
            if (case_seen_reg.ext_lo && !case_seen_reg.ext_up)   flags = flags | FLAG_EXT_LOWER;
        end
        rec_data = '0;
        rec_data[TOTAL_LENGTH*CHAR_W +: FLAGS_W] = flags;
        for (int i = 0; i < TOTAL_LENGTH; i++)
        begin
            if (dots_only)
            begin
                rec_data[i*CHAR_W +: CHAR_W] =
                    (i == 0 || (i == 1 && chars_seen_reg == 2'd2)) ? CHAR_DOT : CHAR_SPACE;
            end
            else
            begin
                rec_data[i*CHAR_W +: CHAR_W] = store_reg[i];
            end
        end
    end

    assign rec_push = take && is_term;

endmodule

/* rtl/snc_queue.sv */
// short queue of finished short-name records between front and back
module snc_queue
    import snc_pkg::*;
#(
    parameter int WIDTH = 8,
    localparam int PTR_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic             q_full,
    output logic             q_valid,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    // pointer wrap at the queue depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)      count_next = count_reg + CNT_W'(1);
        else if (!wr_en && rd_en) count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (rd_en) rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));

endmodule

/* rtl/snc_back.sv */
// back part: streams each short-name record out one byte at a time
module snc_back
    import snc_pkg::*;
#(
    parameter int TOTAL_LENGTH = TOTAL_LENGTH_DEF,
    localparam int REC_W       = TOTAL_LENGTH * CHAR_W + FLAGS_W,
    localparam int IDX_W       = $clog2(TOTAL_LENGTH)
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  logic [REC_W-1:0]   head_data,
    output logic               head_take,
    input  logic               out_pop,
    output logic               out_valid,
    output logic [POS_W-1:0]   out_position,
    output logic [CHAR_W-1:0]  out_byte,
    output logic [FLAGS_W-1:0] out_flags,
    output logic               out_last
);

    logic [CHAR_W-1:0]  byte_arr [TOTAL_LENGTH];
    logic [POS_W-1:0]   k_reg;
    logic               out_valid_reg;
    logic [POS_W-1:0]   position_reg;
    logic [CHAR_W-1:0]  byte_reg;
    logic [FLAGS_W-1:0] flags_reg;
    logic               last_reg;
    logic               load;
    logic               k_last;

    // record bytes
    for (genvar i = 0; i < TOTAL_LENGTH; i++)
    begin : g_unpack
        assign byte_arr[i] = head_data[i*CHAR_W +: CHAR_W];
    end

    assign load      = head_valid && (!out_valid_reg || out_pop);
    assign k_last    = (k_reg == POS_W'(TOTAL_LENGTH - 1));
    assign head_take = load && k_last;

    // byte counter and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            k_reg         <= k_last ? '0 : k_reg + POS_W'(1);
            out_valid_reg <= 1'b1;
        end
        else if (out_pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            position_reg <= k_reg;
            byte_reg     <= byte_arr[k_reg[IDX_W-1:0]];
            flags_reg    <= head_data[TOTAL_LENGTH*CHAR_W +: FLAGS_W];
            last_reg     <= k_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_position = position_reg;
    assign out_byte     = byte_reg;
    assign out_flags    = flags_reg;
    assign out_last     = last_reg;

endmodule
